>>> rtl/toc_pkg.sv
// Shared types and constants of the threshold outlier clusterer.
package toc_pkg;

    localparam logic [0:0] CFG_THRESHOLD  = 1'b0;
    localparam logic [0:0] CFG_WING_WIDTH = 1'b1;

    localparam logic [15:0] THRESHOLD_RESET = 16'd256;
    localparam logic [11:0] WING_RESET      = 12'd0;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [31:0] power;
        logic [31:0] floor_level;
        logic        last_bin;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cluster_number;
        logic [15:0] first_bin;
        logic [16:0] bin_count;
        logic        last_cluster;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic outlier;
        logic last_bin;
    } t_bin_flag;

    typedef struct packed {
        logic push0;
        logic push1;
    } t_push_ctl;

endpackage

>>> rtl/toc_detect.sv
// Input register and outlier test of one bin against the scaled floor.
module toc_detect (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  toc_pkg::t_in_item i_item,
    input  logic [15:0]       i_threshold,
    output toc_pkg::t_bin_flag o_flag
);
    import toc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    t_bin_flag r_flag;
    logic [47:0] product;
    logic [39:0] power_sh;
    logic        outlier;

    assign product  = i_threshold * r_in.floor_level;
    assign power_sh = {r_in.power, 8'h00};
    assign outlier  = 48'(power_sh) > product;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_in       <= '0;
            r_flag     <= '0;
        end else if (i_en) begin
            r_in_valid <= i_valid;
            if (i_valid) begin
                r_in <= i_item;
            end
            r_flag.valid    <= r_in_valid;
            r_flag.outlier  <= outlier;
            r_flag.last_bin <= r_in.last_bin;
        end
    end

    assign o_flag = r_flag;

endmodule

>>> rtl/toc_cluster.sv
// Cluster tracking state and computation of the reported clusters.
module toc_cluster #(
    parameter int MAX_BINS = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  toc_pkg::t_bin_flag  i_bin,
    input  logic [11:0]         i_wing,
    output toc_pkg::t_push_ctl  o_push,
    output toc_pkg::t_out_item  o_res0,
    output toc_pkg::t_out_item  o_res1
);
    import toc_pkg::*;

    localparam int CW = $clog2(MAX_BINS + 1);
    localparam int PW = $clog2(MAX_BINS);
    localparam int AW = ((PW > 13) ? PW : 13) + 2;

    logic [CW-1:0] r_idx;
    logic [PW-1:0] r_first;
    logic [PW-1:0] r_last;
    logic          r_have;
    logic [15:0]   r_cnt;

    logic [CW-1:0] n_idx;
    logic [PW-1:0] n_first;
    logic [PW-1:0] n_last;
    logic          n_have;
    logic [15:0]   n_cnt;

    logic          go;
    logic          in_range;
    logic [PW-1:0] idx_p;
    logic [PW-1:0] gap;
    logic          split;
    logic          emit_nf;
    logic          emit_fin;
    logic [CW-1:0] nbins;
    t_out_item     res_nf;
    t_out_item     res_fin;

    function automatic t_out_item emit(input logic [PW-1:0] first, input logic [PW-1:0] last,
                                       input logic fin, input logic [CW-1:0] nb,
                                       input logic [11:0] wing, input logic [15:0] num);
        logic [AW-1:0] f;
        logic [AW-1:0] l;
        logic [AW-1:0] w;
        logic [AW-1:0] lw;
        logic [AW-1:0] rw;
        logic [AW-1:0] room;
        t_out_item     r;
        f  = AW'(first);
        l  = AW'(last);
        w  = AW'(wing);
        lw = (w < f) ? w : f;
        rw = w;
        if (fin) begin
            room = (AW'(nb) > l) ? (AW'(nb) - l - AW'(1)) : '0;
            if (room < rw) begin
                rw = room;
            end
        end
        r.cluster_number = num;
        r.first_bin      = 16'(f - lw);
        r.bin_count      = 17'(l - f + AW'(1) + lw + rw);
        r.last_cluster   = fin;
        return r;
    endfunction

    assign go       = i_en && i_bin.valid;
    assign in_range = r_idx < CW'(MAX_BINS);
    assign idx_p    = r_idx[PW-1:0];
    assign gap      = idx_p - r_last;
    assign split    = AW'(gap) >= AW'({i_wing, 1'b0});
    assign nbins    = in_range ? (r_idx + CW'(1)) : CW'(MAX_BINS);

    always_comb begin
        n_have  = r_have;
        n_first = r_first;
        n_last  = r_last;
        emit_nf = 1'b0;
        if (in_range && i_bin.outlier) begin
            if (!r_have) begin
                n_have  = 1'b1;
                n_first = idx_p;
                n_last  = idx_p;
            end else if (split) begin
                emit_nf = 1'b1;
                n_first = idx_p;
                n_last  = idx_p;
            end else begin
                n_last = idx_p;
            end
        end
        emit_fin = i_bin.last_bin && n_have;
    end

    assign res_nf  = emit(r_first, r_last, 1'b0, nbins, i_wing, r_cnt);
    assign res_fin = emit(n_first, n_last, 1'b1, nbins, i_wing,
                          emit_nf ? (r_cnt + 16'd1) : r_cnt);

    assign o_push.push0 = go && (emit_nf || emit_fin);
    assign o_push.push1 = go && emit_nf && emit_fin;
    assign o_res0       = emit_nf ? res_nf : res_fin;
    assign o_res1       = res_fin;

    always_comb begin
        n_idx = r_idx;
        n_cnt = r_cnt + 16'(emit_nf);
        if (i_bin.last_bin) begin
            n_idx = '0;
            n_cnt = '0;
        end else if (in_range) begin
            n_idx = r_idx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_first <= '0;
            r_last  <= '0;
            r_have  <= 1'b0;
            r_cnt   <= '0;
        end else if (go) begin
            r_idx <= n_idx;
            r_cnt <= n_cnt;
            if (i_bin.last_bin) begin
                r_first <= '0;
                r_last  <= '0;
                r_have  <= 1'b0;
            end else begin
                r_first <= n_first;
                r_last  <= n_last;
                r_have  <= n_have;
            end
        end
    end

endmodule

>>> rtl/toc_outq.sv
// Result queue that takes up to two results per cycle and delivers one unless the output is stalled.
module toc_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  toc_pkg::t_push_ctl i_push,
    input  toc_pkg::t_out_item i_res0,
    input  toc_pkg::t_out_item i_res1,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output toc_pkg::t_out_item o_out_data,
    output logic               o_room
);
    import toc_pkg::*;

    t_out_item           r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr_ptr;
    logic [OQ_PTR_W-1:0] r_rd_ptr;
    logic [OQ_CNT_W-1:0] r_count;
    logic                pop;

    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_mem[r_rd_ptr];
    assign o_room      = r_count <= OQ_CNT_W'(OQ_DEPTH - 2);
    assign pop         = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OQ_PTR_W'(i_push.push0) + OQ_PTR_W'(i_push.push1);
            r_rd_ptr <= r_rd_ptr + OQ_PTR_W'(pop);
            r_count  <= r_count + OQ_CNT_W'(i_push.push0) + OQ_CNT_W'(i_push.push1)
                        - OQ_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push.push1) begin
            r_mem[r_wr_ptr + OQ_PTR_W'(1)] <= i_res1;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue count exceeds its depth");
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push1 |-> i_push.push0)
        else $error("second result pushed without a first");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push0 |-> r_count <= OQ_CNT_W'(OQ_DEPTH - 2))
        else $error("result pushed without room for two");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push.push0) |=> r_count == $past(r_count) - OQ_CNT_W'(1))
        else $error("delivered result not removed from the queue");
`endif

endmodule

>>> rtl/threshold_outlier_clusterer_top.sv
// Top level of the threshold outlier clusterer: configuration registers and pipeline.
// One spectrum bin is accepted per cycle while the input is not stalled. Its results
// pass through an input register, the registered threshold multiply and compare, then
// the cluster update writing into a four-entry result queue, whose head is presented
// at the output. A bin that closes one cluster and ends the spectrum gives two results,
// which leave the queue one at a time; the input stalls whenever the queue holds
// more than two entries. The threshold (unsigned Q8.8, reset 1.0) and the wing width
// (reset 0) are written through the plain write port; the user must write them only
// while no transfer is in flight, which the block itself does not enforce.
module threshold_outlier_clusterer_top #(
    parameter int MAX_BINS = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  toc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output toc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_wr_en,
    input  logic [0:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import toc_pkg::*;

    logic [15:0] r_threshold;
    logic [11:0] r_wing;
    logic        en;
    t_bin_flag   flag;
    t_push_ctl   push;
    t_out_item   res0;
    t_out_item   res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_wing      <= WING_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_THRESHOLD:  r_threshold <= i_cfg_data;
                CFG_WING_WIDTH: r_wing      <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = !en;

    toc_detect u_detect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in_valid),
        .i_item      (i_in_data),
        .i_threshold (r_threshold),
        .o_flag      (flag)
    );

    toc_cluster #(
        .MAX_BINS (MAX_BINS)
    ) u_cluster (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_bin   (flag),
        .i_wing  (r_wing),
        .o_push  (push),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    toc_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res0      (res0),
        .i_res1      (res1),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_room      (en)
    );

endmodule
